// ===== rtl/lsi_pkg.sv =====
// Shared types, codes and fixed-point helpers for the LSTM sample inference block.
package lsi_pkg;

    // Item commands
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_KNOB = 2'd1;
    localparam logic [1:0] CMD_RUN  = 2'd2;

    // Accumulator width: 24x24 products over up to ~40 terms plus margin
    localparam int ACC_W = 56;

    // Store geometry
    localparam int STORE_DEPTH = 4096;
    localparam int STORE_AW    = 12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_GATE,
        ST_DRAIN,
        ST_CELL,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        C_RD_F,
        C_RD_I,
        C_RD_G,
        C_RD_C,
        C_RD_O,
        C_MUL,
        C_SUM,
        C_WR_C,
        C_MUL_H,
        C_WR_H
    } cell_step_t;

    // Control tag that travels with each dot-product operand pair
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } dot_tag_t;

    typedef struct packed {
        logic               valid;
        logic signed [23:0] value;
    } dot_res_t;

    // Round half up at bit 16, floor, saturate to 24 bits
    function automatic logic signed [23:0] sat_round(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0]  t;
        logic        [ACC_W-17:0] q;
        logic        [ACC_W-40:0] hi;
        t  = v + ACC_W'(32768);
        q  = t[ACC_W-1:16];
        hi = q[ACC_W-17:23];
        if (hi == '0 || hi == '1)
        begin
            return $signed(q[23:0]);
        end
        return q[ACC_W-17] ? 24'sh800000 : 24'sh7FFFFF;
    endfunction

    // Piecewise linear sigmoid on |x|, mirrored for negative x
    function automatic logic signed [17:0] sig_q(input logic signed [25:0] x);
        logic [25:0] a;
        logic [17:0] y;
        a = x[25] ? 26'(-x) : 26'(x);
        if (a >= 26'd327680)
        begin
            y = 18'd65536;
        end
        else if (a >= 26'd155648)
        begin
            y = 18'(a >> 5) + 18'd55296;
        end
        else if (a >= 26'd65536)
        begin
            y = 18'(a >> 3) + 18'd40960;
        end
        else
        begin
            y = 18'(a >> 2) + 18'd32768;
        end
        return x[25] ? $signed(18'd65536 - y) : $signed(y);
    endfunction

    // tanh(x) = 2*sig(2x) - 1
    function automatic logic signed [17:0] tanh_q(input logic signed [23:0] x);
        logic signed [25:0] x2;
        logic signed [18:0] t;
        x2 = {x[23], x, 1'b0};
        t  = $signed({sig_q(x2), 1'b0}) - 19'sd65536;
        return t[17:0];
    endfunction

endpackage

// ===== rtl/lsi_ifs.sv =====
// Request and result channel interfaces for the LSTM sample inference block.
interface lsi_item_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  cmd;
    logic        [11:0] addr;
    logic signed [23:0] value;

    modport source (output valid, output cmd, output addr, output value, input ready);
    modport sink   (input valid, input cmd, input addr, input value, output ready);
endinterface

interface lsi_result_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] sample_out;

    modport source (output valid, output sample_out, input ready);
    modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/lsi_dot.sv =====
// Pipelined multiply-accumulate unit: one operand pair per cycle, one rounded sum per row.
module lsi_dot
(
    input  logic                clk,
    input  logic                rst_n,
    input  lsi_pkg::dot_tag_t   tag,
    input  logic signed [23:0]  w,
    input  logic signed [23:0]  v,
    output lsi_pkg::dot_res_t   res
);

    lsi_pkg::dot_tag_t                  t1_reg;
    lsi_pkg::dot_tag_t                  t2_reg;
    logic signed [lsi_pkg::ACC_W-1:0]   p_reg;
    logic signed [lsi_pkg::ACC_W-1:0]   acc_reg;
    logic signed [lsi_pkg::ACC_W-1:0]   bias_ext;
    logic signed [47:0]                 prod;
    lsi_pkg::dot_res_t                  res_reg;

    // Bias enters as w * 1.0, everything else as w * v
    always_comb
    begin
        bias_ext = lsi_pkg::ACC_W'(w) <<< 16;
        prod     = w * v;
    end

    // Tag pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_reg  <= '0;
            t2_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            t1_reg        <= tag;
            t2_reg        <= t1_reg;
            res_reg.valid <= t2_reg.valid && t2_reg.last;
            res_reg.value <= lsi_pkg::sat_round(acc_reg);
        end
    end

    // Product and accumulate stages
    always_ff @(posedge clk)
    begin
        p_reg <= tag.first ? bias_ext : lsi_pkg::ACC_W'(prod);
        if (t1_reg.valid)
        begin
            acc_reg <= t1_reg.first ? p_reg : acc_reg + p_reg;
        end
    end

    assign res = res_reg;

endmodule

// ===== rtl/lstm_sample_inference.sv =====
// Top level of the stacked LSTM sample inference block with linear output head.
//
// Load items (one parameter word each) and knob items are handled in the idle
// state. A process item runs every layer through one shared multiply-accumulate
// pipeline fed by the parameter store and the state memory, one weight per
// cycle. Each layer has a setup step, the gate sums (4*HIDDEN sums of cols+1
// terms, bias included; cols = layer input width + HIDDEN), a pipeline drain
// and the cell and hidden update. The head forms one sum over the top hidden
// layer and then hands the sample to the output register. The finished
// result sits in an output register, so new items are taken while it waits.
// With zero layers the input sample itself is returned.
module lstm_sample_inference #(
    parameter int HIDDEN       = 16,
    parameter int LAYERS       = 1,
    parameter int EXTRA_INPUTS = 0
)
(
    input  logic        clk,
    input  logic        rst_n,
    lsi_item_if.sink    item,
    lsi_result_if.source result
);

    function automatic int cols_f(input int l);
        return (l == 0 ? 1 + EXTRA_INPUTS : HIDDEN) + HIDDEN;
    endfunction

    function automatic int base_f(input int l);
        int b;
        b = 0;
        for (int i = 0; i < l; i++)
        begin
            b = b + 4 * HIDDEN * cols_f(i) + 6 * HIDDEN;
        end
        return b;
    endfunction

    localparam int TOTAL  = base_f(LAYERS) + HIDDEN + 1;
    localparam int AW0    = $clog2(TOTAL + 1);
    localparam int AW     = AW0 > lsi_pkg::STORE_AW ? AW0 : lsi_pkg::STORE_AW + 1;
    localparam int SD     = (LAYERS > 0 ? LAYERS : 1) * 6 * HIDDEN;
    localparam int SAW    = $clog2(SD);
    localparam int MAXC   = (1 + EXTRA_INPUTS > HIDDEN ? 1 + EXTRA_INPUTS : HIDDEN) + HIDDEN;
    localparam int CW     = $clog2(MAXC + 1);
    localparam int RW     = $clog2(4 * HIDDEN);
    localparam int JW     = HIDDEN > 1 ? $clog2(HIDDEN) : 1;
    localparam int TW     = LAYERS > 0 ? $clog2(LAYERS + 1) : 1;
    localparam int KN     = EXTRA_INPUTS > 0 ? EXTRA_INPUTS : 1;
    localparam int KW     = KN > 1 ? $clog2(KN) : 1;
    localparam int LASTL  = LAYERS > 0 ? LAYERS - 1 : 0;

    // Per-layer geometry; the last entry describes the head
    logic [AW-1:0]  wbase_tb [0:LAYERS];
    logic [AW-1:0]  bias_tb  [0:LAYERS];
    logic [AW-1:0]  hinit_tb [0:LAYERS];
    logic [CW-1:0]  cols_tb  [0:LAYERS];
    logic [CW-1:0]  ni_tb    [0:LAYERS];
    logic [RW-1:0]  rlast_tb [0:LAYERS];
    logic [SAW-1:0] curh_tb  [0:LAYERS];
    logic [SAW-1:0] prevh_tb [0:LAYERS];
    logic [SAW-1:0] gbase_tb [0:LAYERS];

    for (genvar g = 0; g <= LAYERS; g++)
    begin : g_geom
        assign wbase_tb[g] = AW'(base_f(g));
        assign bias_tb[g]  = AW'(g < LAYERS ? base_f(g) + 4 * HIDDEN * cols_f(g)
                                            : base_f(g) + HIDDEN);
        assign hinit_tb[g] = AW'(base_f(g) + 4 * HIDDEN * cols_f(g) + 4 * HIDDEN);
        assign cols_tb[g]  = CW'(g < LAYERS ? cols_f(g) : HIDDEN);
        assign ni_tb[g]    = CW'(g < LAYERS ? cols_f(g) - HIDDEN : 0);
        assign rlast_tb[g] = RW'(g < LAYERS ? 4 * HIDDEN - 1 : 0);
        assign curh_tb[g]  = SAW'(g < LAYERS ? g * 6 * HIDDEN + 4 * HIDDEN
                                             : LASTL * 6 * HIDDEN + 4 * HIDDEN);
        assign prevh_tb[g] = SAW'(g > 0 ? (g - 1) * 6 * HIDDEN + 4 * HIDDEN : 0);
        assign gbase_tb[g] = SAW'(g < LAYERS ? g * 6 * HIDDEN : 0);
    end

    lsi_pkg::state_t     state_reg, state_next;
    lsi_pkg::cell_step_t cstep_reg;

    logic [TW-1:0]      layer_reg;
    logic [RW-1:0]      r_reg, rescnt_reg, rlast_reg;
    logic [CW-1:0]      k_reg, cols_reg, ni_reg;
    logic [AW-1:0]      wptr_reg, bptr_reg;
    logic [SAW-1:0]     curh_reg, prevh_reg, gbase_reg;
    logic [JW-1:0]      j_reg;
    logic signed [23:0] sample_reg, hold_reg, out_data_reg;
    logic               out_valid_reg;
    logic signed [23:0] knob_reg [0:KN-1];

    // Memories
    logic signed [23:0] wmem [0:lsi_pkg::STORE_DEPTH-1];
    logic signed [23:0] smem [0:SD-1];
    logic signed [23:0] wrd_reg, srd_reg;
    logic               oob_reg;

    // Issue side
    logic [AW-1:0]      wraddr;
    logic [SAW-1:0]     sraddr, swaddr;
    logic               swe;
    logic signed [23:0] swdata;
    lsi_pkg::dot_tag_t  iss_tag, tag_reg;
    logic               use_x, use_x_reg;
    logic signed [23:0] xval, x_reg;
    logic [CW-1:0]      e;
    lsi_pkg::dot_res_t  dres;
    logic               is_head, accept, gate_last;

    // Load targeting a live hidden or cell value
    logic               ld_hit;
    logic [SAW-1:0]     ld_sidx;
    logic [AW-1:0]      ld_addr;

    // Cell update datapath
    logic signed [17:0] sf_reg, si_reg, tg_reg, so_reg, tc_reg;
    logic signed [23:0] cold_reg, cnew_reg;
    logic signed [47:0] p1_reg, p2_reg;
    logic signed [lsi_pkg::ACC_W-1:0] csum;
    logic [SAW-1:0]     joff;

    assign is_head   = (layer_reg == TW'(LAYERS));
    assign accept    = item.valid && item.ready;
    assign e         = k_reg - CW'(1);
    assign gate_last = (r_reg == rlast_reg) && (k_reg == cols_reg);
    assign joff      = SAW'(j_reg);
    assign csum      = lsi_pkg::ACC_W'(p1_reg) + lsi_pkg::ACC_W'(p2_reg);
    assign ld_addr   = AW'(item.addr);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        item.ready = (state_reg == lsi_pkg::ST_IDLE);
        case (state_reg)
            lsi_pkg::ST_IDLE:
            begin
                if (accept && item.cmd == lsi_pkg::CMD_RUN)
                begin
                    state_next = (LAYERS == 0) ? lsi_pkg::ST_DONE : lsi_pkg::ST_SETUP;
                end
            end
            lsi_pkg::ST_SETUP:
            begin
                state_next = lsi_pkg::ST_GATE;
            end
            lsi_pkg::ST_GATE:
            begin
                if (gate_last)
                begin
                    state_next = lsi_pkg::ST_DRAIN;
                end
            end
            lsi_pkg::ST_DRAIN:
            begin
                if (dres.valid && rescnt_reg == rlast_reg)
                begin
                    state_next = is_head ? lsi_pkg::ST_DONE : lsi_pkg::ST_CELL;
                end
            end
            lsi_pkg::ST_CELL:
            begin
                if (cstep_reg == lsi_pkg::C_WR_H && j_reg == JW'(HIDDEN - 1))
                begin
                    state_next = lsi_pkg::ST_SETUP;
                end
            end
            lsi_pkg::ST_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = lsi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsi_pkg::ST_IDLE;
            end
        endcase
    end

    // Operand issue for the gate and head dot products
    always_comb
    begin
        iss_tag.valid = (state_reg == lsi_pkg::ST_GATE);
        iss_tag.first = (k_reg == '0);
        iss_tag.last  = (k_reg == cols_reg);
        use_x         = (k_reg != '0) && (layer_reg == '0) && (e < ni_reg);
        xval          = (e == '0) ? sample_reg : knob_reg[KW'(e - CW'(1))];
        wraddr        = (k_reg == '0) ? bptr_reg : wptr_reg;
        if (state_reg == lsi_pkg::ST_CELL)
        begin
            case (cstep_reg)
                lsi_pkg::C_RD_F: sraddr = gbase_reg + SAW'(HIDDEN) + joff;
                lsi_pkg::C_RD_I: sraddr = gbase_reg + joff;
                lsi_pkg::C_RD_G: sraddr = gbase_reg + SAW'(2 * HIDDEN) + joff;
                lsi_pkg::C_RD_C: sraddr = gbase_reg + SAW'(5 * HIDDEN) + joff;
                default:         sraddr = gbase_reg + SAW'(3 * HIDDEN) + joff;
            endcase
        end
        else if (e < ni_reg)
        begin
            sraddr = prevh_reg + SAW'(e);
        end
        else
        begin
            sraddr = curh_reg + SAW'(e - ni_reg);
        end
    end

    // Load address decode into live state
    always_comb
    begin
        ld_hit  = 1'b0;
        ld_sidx = '0;
        for (int g = 0; g < LAYERS; g++)
        begin
            if (ld_addr >= hinit_tb[g] && ld_addr < hinit_tb[g] + AW'(2 * HIDDEN))
            begin
                ld_hit  = 1'b1;
                ld_sidx = curh_tb[g] + SAW'(ld_addr - hinit_tb[g]);
            end
        end
    end

    // State memory write port
    always_comb
    begin
        swe    = 1'b0;
        swaddr = '0;
        swdata = item.value;
        if (dres.valid && !is_head)
        begin
            swe    = 1'b1;
            swaddr = gbase_reg + SAW'(rescnt_reg);
            swdata = dres.value;
        end
        else if (state_reg == lsi_pkg::ST_CELL && cstep_reg == lsi_pkg::C_WR_C)
        begin
            swe    = 1'b1;
            swaddr = gbase_reg + SAW'(5 * HIDDEN) + joff;
            swdata = cnew_reg;
        end
        else if (state_reg == lsi_pkg::ST_CELL && cstep_reg == lsi_pkg::C_WR_H)
        begin
            swe    = 1'b1;
            swaddr = gbase_reg + SAW'(4 * HIDDEN) + joff;
            swdata = lsi_pkg::sat_round(lsi_pkg::ACC_W'(p1_reg));
        end
        else if (accept && item.cmd == lsi_pkg::CMD_LOAD && ld_hit)
        begin
            swe    = 1'b1;
            swaddr = ld_sidx;
        end
    end

    // Parameter store
    always_ff @(posedge clk)
    begin
        if (accept && item.cmd == lsi_pkg::CMD_LOAD)
        begin
            wmem[item.addr] <= item.value;
        end
        wrd_reg <= wmem[wraddr[lsi_pkg::STORE_AW-1:0]];
        oob_reg <= (wraddr[AW-1:lsi_pkg::STORE_AW] != '0);
    end

    // State memory: gate sums, live hidden and cell values per layer
    always_ff @(posedge clk)
    begin
        if (swe)
        begin
            smem[swaddr] <= swdata;
        end
        srd_reg <= smem[sraddr];
    end

    lsi_dot u_dot
    (
        .clk   (clk),
        .rst_n (rst_n),
        .tag   (tag_reg),
        .w     (oob_reg ? 24'sd0 : wrd_reg),
        .v     (use_x_reg ? x_reg : srd_reg),
        .res   (dres)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lsi_pkg::ST_IDLE;
            cstep_reg     <= lsi_pkg::C_RD_F;
            layer_reg     <= '0;
            r_reg         <= '0;
            k_reg         <= '0;
            rescnt_reg    <= '0;
            j_reg         <= '0;
            tag_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < KN; i++)
            begin
                knob_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            tag_reg   <= iss_tag;

            // Knob writes
            if (accept && item.cmd == lsi_pkg::CMD_KNOB && item.addr < 12'(EXTRA_INPUTS))
            begin
                knob_reg[KW'(item.addr)] <= item.value;
            end

            // Output register
            if (state_reg == lsi_pkg::ST_DONE && (!out_valid_reg || result.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (dres.valid)
            begin
                rescnt_reg <= rescnt_reg + RW'(1);
            end

            case (state_reg)
                lsi_pkg::ST_IDLE:
                begin
                    layer_reg <= '0;
                end
                lsi_pkg::ST_SETUP:
                begin
                    r_reg      <= '0;
                    k_reg      <= '0;
                    rescnt_reg <= '0;
                    j_reg      <= '0;
                    cstep_reg  <= lsi_pkg::C_RD_F;
                end
                lsi_pkg::ST_GATE:
                begin
                    if (k_reg == cols_reg)
                    begin
                        k_reg <= '0;
                        r_reg <= r_reg + RW'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + CW'(1);
                    end
                end
                lsi_pkg::ST_CELL:
                begin
                    if (cstep_reg == lsi_pkg::C_WR_H)
                    begin
                        cstep_reg <= lsi_pkg::C_RD_F;
                        j_reg     <= j_reg + JW'(1);
                        if (j_reg == JW'(HIDDEN - 1))
                        begin
                            layer_reg <= layer_reg + TW'(1);
                        end
                    end
                    else
                    begin
                        cstep_reg <= lsi_pkg::cell_step_t'(cstep_reg + 4'd1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        x_reg     <= xval;
        use_x_reg <= use_x;

        if (accept && item.cmd == lsi_pkg::CMD_RUN)
        begin
            sample_reg <= item.value;
            hold_reg   <= item.value;
        end
        if (dres.valid && is_head)
        begin
            hold_reg <= dres.value;
        end
        if (state_reg == lsi_pkg::ST_DONE && (!out_valid_reg || result.ready))
        begin
            out_data_reg <= hold_reg;
        end

        // Layer geometry
        if (state_reg == lsi_pkg::ST_SETUP)
        begin
            wptr_reg  <= wbase_tb[layer_reg];
            bptr_reg  <= bias_tb[layer_reg];
            cols_reg  <= cols_tb[layer_reg];
            ni_reg    <= ni_tb[layer_reg];
            rlast_reg <= rlast_tb[layer_reg];
            curh_reg  <= curh_tb[layer_reg];
            prevh_reg <= prevh_tb[layer_reg];
            gbase_reg <= gbase_tb[layer_reg];
        end
        else if (state_reg == lsi_pkg::ST_GATE)
        begin
            if (k_reg == cols_reg)
            begin
                bptr_reg <= bptr_reg + AW'(1);
            end
            if (k_reg != '0)
            begin
                wptr_reg <= wptr_reg + AW'(1);
            end
        end

        // Cell and hidden update steps
        if (state_reg == lsi_pkg::ST_CELL)
        begin
            case (cstep_reg)
                lsi_pkg::C_RD_I:  sf_reg   <= lsi_pkg::sig_q({{2{srd_reg[23]}}, srd_reg});
                lsi_pkg::C_RD_G:  si_reg   <= lsi_pkg::sig_q({{2{srd_reg[23]}}, srd_reg});
                lsi_pkg::C_RD_C:  tg_reg   <= lsi_pkg::tanh_q(srd_reg);
                lsi_pkg::C_RD_O:  cold_reg <= srd_reg;
                lsi_pkg::C_MUL:
                begin
                    so_reg <= lsi_pkg::sig_q({{2{srd_reg[23]}}, srd_reg});
                    p1_reg <= sf_reg * cold_reg;
                    p2_reg <= si_reg * tg_reg;
                end
                lsi_pkg::C_SUM:   cnew_reg <= lsi_pkg::sat_round(csum);
                lsi_pkg::C_WR_C:  tc_reg   <= lsi_pkg::tanh_q(cnew_reg);
                lsi_pkg::C_MUL_H: p1_reg   <= so_reg * tc_reg;
                default:
                begin
                end
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.sample_out = out_data_reg;

endmodule
